// File: src/vajl_pkg.sv
// vajl_pkg: shared types and constants for the velocity/acceleration/jerk limiter
// item, configuration and inter-stage structs, register index codes
// no dependencies
`default_nettype none

package vajl_pkg;

   localparam int VAL_W     = 32;
   localparam int DT_W      = 16;
   localparam int CSR_IDX_W = 3;

   // register index codes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_MASK = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_MIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_MAX     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_MIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_MAX   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_JERK_MIN    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_JERK_MAX    = 3'd6;

   // enable_mask bit positions
   localparam int EN_VEL   = 0;
   localparam int EN_ACCEL = 1;
   localparam int EN_JERK  = 2;

   typedef struct packed {
      logic signed [VAL_W-1:0] cmd;
      logic signed [VAL_W-1:0] v0;
      logic signed [VAL_W-1:0] v1;
      logic        [DT_W-1:0]  dt;
   } req_type;

   typedef struct packed {
      logic        [2:0]       enable_mask;
      logic signed [VAL_W-1:0] vel_min;
      logic signed [VAL_W-1:0] vel_max;
      logic signed [VAL_W-1:0] accel_min;
      logic signed [VAL_W-1:0] accel_max;
      logic signed [VAL_W-1:0] jerk_min;
      logic signed [VAL_W-1:0] jerk_max;
   } cfg_type;

   // item plus scaled bounds, out of the multiplier stages
   typedef struct packed {
      logic signed [VAL_W-1:0] cmd;
      logic signed [VAL_W-1:0] v0;
      logic signed [VAL_W-1:0] v1;
      logic signed [VAL_W:0]   jerk_lo;
      logic signed [VAL_W:0]   jerk_hi;
      logic signed [VAL_W-1:0] accel_lo;
      logic signed [VAL_W-1:0] accel_hi;
   } bound_type;

   // limited velocity with its command, into the ratio divider
   typedef struct packed {
      logic signed [VAL_W-1:0] cmd;
      logic signed [VAL_W-1:0] vel;
   } lim_type;

endpackage

`default_nettype wire

// File: src/vajl_bounds.sv
// vajl_bounds: two register stages that scale the jerk and acceleration bounds
// by dt*dt and dt; depends on vajl_pkg
`default_nettype none

module vajl_bounds import vajl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  req_type   in_req,
   input  cfg_type   cfg,
   output logic      out_valid,
   output bound_type out_bound
);

   localparam int ACC_W  = VAL_W + DT_W + 1;
   localparam int JERK_W = 2 * VAL_W + 1;

   // stage 1: dt squared and accel products
   logic                    s1_valid_ff;
   req_type                 s1_req_ff;
   logic [2*DT_W-1:0]       s1_dt_sq_ff, s1_dt_sq_in;
   logic signed [VAL_W-1:0] s1_acc_lo_ff, s1_acc_lo_in;
   logic signed [VAL_W-1:0] s1_acc_hi_ff, s1_acc_hi_in;
   logic signed [ACC_W-1:0] acc_lo_prod, acc_hi_prod;

   // stage 2: jerk products
   logic                        s2_valid_ff;
   bound_type                   s2_bound_ff, s2_bound_in;
   logic signed [JERK_W-1:0]    jerk_lo_prod, jerk_hi_prod;

   always_comb begin
      s1_dt_sq_in  = (2*DT_W)'(in_req.dt) * (2*DT_W)'(in_req.dt);
      acc_lo_prod  = ACC_W'(cfg.accel_min) * ACC_W'($signed({1'b0, in_req.dt}));
      acc_hi_prod  = ACC_W'(cfg.accel_max) * ACC_W'($signed({1'b0, in_req.dt}));
      // arithmetic shift right by DT_W, rounds toward minus infinity
      s1_acc_lo_in = acc_lo_prod[VAL_W+DT_W-1:DT_W];
      s1_acc_hi_in = acc_hi_prod[VAL_W+DT_W-1:DT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff    <= in_req;
      s1_dt_sq_ff  <= s1_dt_sq_in;
      s1_acc_lo_ff <= s1_acc_lo_in;
      s1_acc_hi_ff <= s1_acc_hi_in;
   end

   always_comb begin
      jerk_lo_prod         = JERK_W'(cfg.jerk_min) * JERK_W'($signed({1'b0, s1_dt_sq_ff}));
      jerk_hi_prod         = JERK_W'(cfg.jerk_max) * JERK_W'($signed({1'b0, s1_dt_sq_ff}));
      s2_bound_in.cmd      = s1_req_ff.cmd;
      s2_bound_in.v0       = s1_req_ff.v0;
      s2_bound_in.v1       = s1_req_ff.v1;
      // shift right by 2*DT_W-1, keeps 33 bits
      s2_bound_in.jerk_lo  = jerk_lo_prod[2*VAL_W-1:2*DT_W-1];
      s2_bound_in.jerk_hi  = jerk_hi_prod[2*VAL_W-1:2*DT_W-1];
      s2_bound_in.accel_lo = s1_acc_lo_ff;
      s2_bound_in.accel_hi = s1_acc_hi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_bound_ff <= s2_bound_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_bound = s2_bound_ff;

endmodule

`default_nettype wire

// File: src/vajl_clamp.sv
// vajl_clamp: three register stages applying the jerk, acceleration and
// velocity limits in turn; depends on vajl_pkg
`default_nettype none

module vajl_clamp import vajl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  bound_type in_bound,
   input  cfg_type   cfg,
   output logic      out_valid,
   output lim_type   out_lim
);

   localparam int SUM_W = 36;
   localparam logic signed [SUM_W-1:0] S32_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [SUM_W-1:0] S32_MIN = -36'sh0_8000_0000;

   function automatic logic signed [SUM_W-1:0] clamp36(
      input logic signed [SUM_W-1:0] x,
      input logic signed [SUM_W-1:0] lo,
      input logic signed [SUM_W-1:0] hi
   );
      logic signed [SUM_W-1:0] t;
      t = (x < lo) ? lo : x;
      return (t > hi) ? hi : t;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] t;
      t = (x > S32_MAX) ? S32_MAX : ((x < S32_MIN) ? S32_MIN : x);
      return t[VAL_W-1:0];
   endfunction

   // stage 3: jerk limit
   logic                    s3_valid_ff;
   logic signed [VAL_W-1:0] s3_cmd_ff, s3_v0_ff, s3_vel_ff, s3_vel_in;
   logic signed [VAL_W-1:0] s3_acc_lo_ff, s3_acc_hi_ff;
   logic signed [SUM_W-1:0] jk_raw, jk_dd, jk_base;

   // stage 4: acceleration limit
   logic                    s4_valid_ff;
   logic signed [VAL_W-1:0] s4_cmd_ff, s4_vel_ff, s4_vel_in;
   logic signed [SUM_W-1:0] ac_raw, ac_d;

   // stage 5: velocity limit
   logic                    s5_valid_ff;
   lim_type                 s5_lim_ff, s5_lim_in;
   logic signed [SUM_W-1:0] vl_clamped;

   always_comb begin
      // second difference v - 2*v0 + v1
      jk_raw  = SUM_W'($signed(in_bound.cmd)) - SUM_W'($signed(in_bound.v0))
              - SUM_W'($signed(in_bound.v0)) + SUM_W'($signed(in_bound.v1));
      jk_dd   = clamp36(jk_raw, SUM_W'($signed(in_bound.jerk_lo)),
                        SUM_W'($signed(in_bound.jerk_hi)));
      jk_base = SUM_W'($signed(in_bound.v0)) + SUM_W'($signed(in_bound.v0))
              - SUM_W'($signed(in_bound.v1));
      s3_vel_in = cfg.enable_mask[EN_JERK] ? sat32(jk_base + jk_dd) : in_bound.cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s3_cmd_ff    <= in_bound.cmd;
      s3_v0_ff     <= in_bound.v0;
      s3_vel_ff    <= s3_vel_in;
      s3_acc_lo_ff <= in_bound.accel_lo;
      s3_acc_hi_ff <= in_bound.accel_hi;
   end

   always_comb begin
      ac_raw    = SUM_W'($signed(s3_vel_ff)) - SUM_W'($signed(s3_v0_ff));
      ac_d      = clamp36(ac_raw, SUM_W'($signed(s3_acc_lo_ff)),
                          SUM_W'($signed(s3_acc_hi_ff)));
      s4_vel_in = cfg.enable_mask[EN_ACCEL] ? sat32(SUM_W'($signed(s3_v0_ff)) + ac_d)
                                            : s3_vel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_cmd_ff <= s3_cmd_ff;
      s4_vel_ff <= s4_vel_in;
   end

   always_comb begin
      vl_clamped    = clamp36(SUM_W'($signed(s4_vel_ff)), SUM_W'($signed(cfg.vel_min)),
                              SUM_W'($signed(cfg.vel_max)));
      s5_lim_in.cmd = s4_cmd_ff;
      s5_lim_in.vel = cfg.enable_mask[EN_VEL] ? vl_clamped[VAL_W-1:0] : s4_vel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_lim_ff <= s5_lim_in;
   end

   assign out_valid = s5_valid_ff;
   assign out_lim   = s5_lim_ff;

endmodule

`default_nettype wire

// File: src/vajl_div.sv
// vajl_div: pipelined restoring divider, one quotient bit per stage, for the
// ratio (vel << FRAC_BITS) / cmd with saturation; depends on vajl_pkg
`default_nettype none

module vajl_div import vajl_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  lim_type                 in_lim,
   output logic                    out_valid,
   output logic signed [VAL_W-1:0] out_velocity,
   output logic signed [VAL_W-1:0] out_ratio
);

   localparam int QW = VAL_W + FRAC_BITS;
   localparam logic [VAL_W-1:0] RATIO_ONE = VAL_W'(1) << FRAC_BITS;
   localparam logic [QW-1:0]    Q_POS_LIM = QW'(32'h7FFF_FFFF);
   localparam logic [QW-1:0]    Q_NEG_LIM = QW'(32'h8000_0000);
   localparam logic [VAL_W-1:0] RATIO_MAX = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] RATIO_MIN = 32'h8000_0000;

   // stage 0 is setup, stage g+1 holds the state after quotient bit g
   logic                    st_valid_ff [QW+1];
   logic [VAL_W-1:0]        st_rem_ff   [QW+1];
   logic [QW-1:0]           st_aq_ff    [QW+1];
   logic [VAL_W-1:0]        st_div_ff   [QW+1];
   logic                    st_neg_ff   [QW+1];
   logic                    st_zero_ff  [QW+1];
   logic signed [VAL_W-1:0] st_vel_ff   [QW+1];

   logic [VAL_W-1:0] vel_u, cmd_u, vel_mag_in, cmd_mag_in;

   logic                    out_valid_ff;
   logic signed [VAL_W-1:0] out_vel_ff;
   logic [VAL_W-1:0]        out_ratio_ff, out_ratio_in;
   logic [QW-1:0]           q_mag, q_neg;

   always_comb begin
      vel_u      = in_lim.vel;
      cmd_u      = in_lim.cmd;
      vel_mag_in = vel_u[VAL_W-1] ? (~vel_u + VAL_W'(1)) : vel_u;
      cmd_mag_in = cmd_u[VAL_W-1] ? (~cmd_u + VAL_W'(1)) : cmd_u;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff[0] <= 1'b0;
      end else begin
         st_valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      st_rem_ff[0]  <= '0;
      st_aq_ff[0]   <= {vel_mag_in, {FRAC_BITS{1'b0}}};
      st_div_ff[0]  <= cmd_mag_in;
      st_neg_ff[0]  <= vel_u[VAL_W-1] ^ cmd_u[VAL_W-1];
      st_zero_ff[0] <= (cmd_u == '0);
      st_vel_ff[0]  <= in_lim.vel;
   end

   for (genvar g = 0; g < QW; g++) begin : g_stage
      logic [VAL_W:0]   trial, diff;
      logic             take;
      logic [VAL_W-1:0] rem_in;
      logic [QW-1:0]    aq_in;

      always_comb begin
         trial  = {st_rem_ff[g], st_aq_ff[g][QW-1]};
         diff   = trial - {1'b0, st_div_ff[g]};
         take   = (trial >= {1'b0, st_div_ff[g]});
         rem_in = take ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
         aq_in  = {st_aq_ff[g][QW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[g+1] <= 1'b0;
         end else begin
            st_valid_ff[g+1] <= st_valid_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         st_rem_ff[g+1]  <= rem_in;
         st_aq_ff[g+1]   <= aq_in;
         st_div_ff[g+1]  <= st_div_ff[g];
         st_neg_ff[g+1]  <= st_neg_ff[g];
         st_zero_ff[g+1] <= st_zero_ff[g];
         st_vel_ff[g+1]  <= st_vel_ff[g];
      end
   end

   // sign fix-up and saturation
   always_comb begin
      q_mag = st_aq_ff[QW];
      q_neg = ~q_mag + QW'(1);
      if (st_zero_ff[QW]) begin
         out_ratio_in = RATIO_ONE;
      end else if (st_neg_ff[QW]) begin
         out_ratio_in = (q_mag > Q_NEG_LIM) ? RATIO_MIN : q_neg[VAL_W-1:0];
      end else begin
         out_ratio_in = (q_mag > Q_POS_LIM) ? RATIO_MAX : q_mag[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= st_valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      out_vel_ff   <= st_vel_ff[QW];
      out_ratio_ff <= out_ratio_in;
   end

   assign out_valid    = out_valid_ff;
   assign out_velocity = out_vel_ff;
   assign out_ratio    = out_ratio_ff;

endmodule

`default_nettype wire

// File: src/velocity_accel_jerk_limiter.sv
// velocity_accel_jerk_limiter: registered pipeline of bound scaling, clamps and the
// one-bit-per-stage ratio divider; one item per cycle, busy is never raised
// reset clears the valid bits of every stage and all limit registers to zero
// rsp_valid strobes for one cycle per item; the receiver cannot hold results off
// depends on vajl_pkg, vajl_bounds, vajl_clamp, vajl_div
`default_nettype none

module velocity_accel_jerk_limiter import vajl_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // item input
   input  logic                    start,
   output logic                    busy,
   input  logic signed [VAL_W-1:0] req_cmd_velocity,
   input  logic signed [VAL_W-1:0] req_prev_velocity,
   input  logic signed [VAL_W-1:0] req_prev2_velocity,
   input  logic        [DT_W-1:0]  req_time_step,
   // result output
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_limited_velocity,
   output logic signed [VAL_W-1:0] rsp_scale_ratio,
   // limit registers
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [VAL_W-1:0]        csr_wdata
);

   // bounds 2 + clamps 3 + divider setup, one per quotient bit, output
   localparam int LATENCY = 7 + VAL_W + FRAC_BITS;
   localparam logic [VAL_W-1:0] RATIO_ONE = VAL_W'(1) << FRAC_BITS;

   // limit registers; the user must write them only while no item is in flight, the block does not enforce it
   logic [2:0]              enable_mask_ff;
   logic signed [VAL_W-1:0] vel_min_ff, vel_max_ff;
   logic signed [VAL_W-1:0] accel_min_ff, accel_max_ff;
   logic signed [VAL_W-1:0] jerk_min_ff, jerk_max_ff;

   cfg_type   cfg;
   req_type   req;
   logic      bnd_valid, lim_valid;
   bound_type bnd;
   lim_type   lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff <= '0;
         vel_min_ff     <= '0;
         vel_max_ff     <= '0;
         accel_min_ff   <= '0;
         accel_max_ff   <= '0;
         jerk_min_ff    <= '0;
         jerk_max_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ENABLE_MASK: enable_mask_ff <= csr_wdata[2:0];
            CSR_VEL_MIN:     vel_min_ff     <= csr_wdata;
            CSR_VEL_MAX:     vel_max_ff     <= csr_wdata;
            CSR_ACCEL_MIN:   accel_min_ff   <= csr_wdata;
            CSR_ACCEL_MAX:   accel_max_ff   <= csr_wdata;
            CSR_JERK_MIN:    jerk_min_ff    <= csr_wdata;
            CSR_JERK_MAX:    jerk_max_ff    <= csr_wdata;
            default: begin
               // index beyond the register list: write is dropped
            end
         endcase
      end
   end

   always_comb begin
      cfg.enable_mask = enable_mask_ff;
      cfg.vel_min     = vel_min_ff;
      cfg.vel_max     = vel_max_ff;
      cfg.accel_min   = accel_min_ff;
      cfg.accel_max   = accel_max_ff;
      cfg.jerk_min    = jerk_min_ff;
      cfg.jerk_max    = jerk_max_ff;
      req.cmd         = req_cmd_velocity;
      req.v0          = req_prev_velocity;
      req.v1          = req_prev2_velocity;
      req.dt          = req_time_step;
   end

   // fully pipelined, a new item can enter every cycle
   assign busy = 1'b0;

   // scale jerk bounds by dt*dt and accel bounds by dt
   vajl_bounds u_bounds (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req),
      .cfg       (cfg),
      .out_valid (bnd_valid),
      .out_bound (bnd)
   );

   // jerk, then acceleration, then velocity limit, one stage each
   vajl_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (bnd_valid),
      .in_bound  (bnd),
      .cfg       (cfg),
      .out_valid (lim_valid),
      .out_lim   (lim)
   );

   // limited over commanded ratio, registered outputs
   vajl_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (lim_valid),
      .in_lim       (lim),
      .out_valid    (rsp_valid),
      .out_velocity (rsp_limited_velocity),
      .out_ratio    (rsp_scale_ratio)
   );

   // every result traces back to an item taken with start high and busy low
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching item");

   // zero command gives a ratio of one
   a_zero_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(start && (req_cmd_velocity == '0), LATENCY)
      |-> rsp_scale_ratio == RATIO_ONE)
      else $error("zero command ratio is not one");

   // zero limited velocity over a nonzero command gives a zero ratio
   a_zero_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(start && (req_cmd_velocity != '0), LATENCY)
      && (rsp_limited_velocity == '0) |-> rsp_scale_ratio == '0)
      else $error("zero velocity ratio is not zero");

endmodule

`default_nettype wire

// File: tb/tb_velocity_accel_jerk_limiter.sv
// tb_velocity_accel_jerk_limiter: self-checking bench for the jerk/accel/velocity limiter
// holds its own limit predictor in a small scoreboard class, drives items and limit registers
// depends on vajl_pkg and velocity_accel_jerk_limiter
`timescale 1ns / 1ps

module tb_velocity_accel_jerk_limiter import vajl_pkg::*; ();

   localparam int FRAC    = 16;
   localparam int LATENCY = 39 + FRAC;
   localparam int PHASES  = 16;
   localparam int PER_PHASE = 69;

   localparam logic signed [VAL_W-1:0] VMAX = 32'sh7FFF_FFFF;
   localparam logic signed [VAL_W-1:0] VMIN = 32'sh8000_0000;

   localparam logic [2:0] M_VEL   = 3'(1 << EN_VEL);
   localparam logic [2:0] M_ACCEL = 3'(1 << EN_ACCEL);
   localparam logic [2:0] M_JERK  = 3'(1 << EN_JERK);

   typedef struct packed {
      logic signed [VAL_W-1:0] vel;
      logic signed [VAL_W-1:0] ratio;
   } limit_out_type;

   // predicted limiter outputs, checked in arrival order
   class vel_limit_scoreboard;
      cfg_type       regs;
      limit_out_type expected_limits[$];
      int            mismatches;
      int            compared;

      function new();
         regs = '0;
         mismatches = 0;
         compared = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
         case (idx)
            CSR_ENABLE_MASK: regs.enable_mask = data[2:0];
            CSR_VEL_MIN:     regs.vel_min = data;
            CSR_VEL_MAX:     regs.vel_max = data;
            CSR_ACCEL_MIN:   regs.accel_min = data;
            CSR_ACCEL_MAX:   regs.accel_max = data;
            CSR_JERK_MIN:    regs.jerk_min = data;
            CSR_JERK_MAX:    regs.jerk_max = data;
            default: ;
         endcase
      endfunction

      function longint sat32(longint x);
         if (x > longint'(VMAX)) return longint'(VMAX);
         if (x < longint'(VMIN)) return longint'(VMIN);
         return x;
      endfunction

      // min(max(x, lo), hi): an inverted pair yields hi
      function longint clip(longint x, longint lo, longint hi);
         if (x < lo) x = lo;
         if (x > hi) x = hi;
         return x;
      endfunction

      function limit_out_type limit_velocity(req_type r);
         longint        cmd, v0, v1, dt, v, lo, hi, d0, dd, d, ratio;
         limit_out_type res;
         cmd = longint'(r.cmd);
         v0  = longint'(r.v0);
         v1  = longint'(r.v1);
         dt  = longint'(r.dt);
         v   = cmd;
         // jerk stage: second difference against bound * 2*dt^2 (Q0.32 >> 31)
         if (regs.enable_mask[EN_JERK]) begin
            lo = (longint'(regs.jerk_min) * (dt * dt)) >>> (2 * DT_W - 1);
            hi = (longint'(regs.jerk_max) * (dt * dt)) >>> (2 * DT_W - 1);
            d0 = v0 - v1;
            dd = clip(v - v0 - d0, lo, hi);
            v  = sat32(v0 + d0 + dd);
         end
         // acceleration stage: first difference against bound * dt
         if (regs.enable_mask[EN_ACCEL]) begin
            lo = (longint'(regs.accel_min) * dt) >>> DT_W;
            hi = (longint'(regs.accel_max) * dt) >>> DT_W;
            d  = clip(v - v0, lo, hi);
            v  = sat32(v0 + d);
         end
         if (regs.enable_mask[EN_VEL])
            v = clip(v, longint'(regs.vel_min), longint'(regs.vel_max));
         // ratio truncates toward zero, 1.0 for a zero command
         if (cmd == 0)
            ratio = longint'(1) << FRAC;
         else
            ratio = sat32((v * (longint'(1) << FRAC)) / cmd);
         res.vel   = v[VAL_W-1:0];
         res.ratio = ratio[VAL_W-1:0];
         return res;
      endfunction

      function void note_command(req_type r);
         expected_limits.push_back(limit_velocity(r));
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] %s", $realtime, msg);
      endfunction

      function void check_limited(logic signed [VAL_W-1:0] vel,
                                  logic signed [VAL_W-1:0] ratio);
         limit_out_type want;
         if (expected_limits.size() == 0) begin
            flag($sformatf("result with nothing pending: vel %0d ratio %0d", vel, ratio));
            return;
         end
         want = expected_limits.pop_front();
         compared++;
         if (want.vel !== vel)
            flag($sformatf("limited_velocity exp %0d got %0d", want.vel, vel));
         if (want.ratio !== ratio)
            flag($sformatf("scale_ratio exp %0d got %0d (vel %0d)", want.ratio, ratio, vel));
      endfunction

      function int pending();
         return expected_limits.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic signed [VAL_W-1:0] req_cmd_velocity;
   logic signed [VAL_W-1:0] req_prev_velocity;
   logic signed [VAL_W-1:0] req_prev2_velocity;
   logic        [DT_W-1:0]  req_time_step;
   logic                    rsp_valid;
   logic signed [VAL_W-1:0] rsp_limited_velocity;
   logic signed [VAL_W-1:0] rsp_scale_ratio;
   logic                    csr_write_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [VAL_W-1:0]        csr_wdata;

   vel_limit_scoreboard sb;
   int items_sent = 0;
   int settings_used = 0;

   velocity_accel_jerk_limiter #(
      .FRAC_BITS(FRAC)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_cmd_velocity     (req_cmd_velocity),
      .req_prev_velocity    (req_prev_velocity),
      .req_prev2_velocity   (req_prev2_velocity),
      .req_time_step        (req_time_step),
      .rsp_valid            (rsp_valid),
      .rsp_limited_velocity (rsp_limited_velocity),
      .rsp_scale_ratio      (rsp_scale_ratio),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // results cannot be held off: every strobe is checked on the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_limited(rsp_limited_velocity, rsp_scale_ratio);
   end

   // symmetric random value in [-a, a]
   function automatic int signed_span(int a);
      return int'($urandom_range(0, 2 * a)) - a;
   endfunction

   // corner values of a 32-bit signed field, with a random one mixed in
   function automatic logic signed [VAL_W-1:0] corner_word();
      case ($urandom_range(0, 5))
         0: return VMIN;
         1: return VMAX;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return $urandom();
      endcase
   endfunction

   // mostly smooth velocity histories near the limits, plus noise and corners
   function automatic req_type rand_command();
      req_type r;
      int      k;
      k = $urandom_range(0, 19);
      if (k < 14) begin
         r.v1  = signed_span(30 << 16);
         r.v0  = r.v1 + signed_span(2 << 16);
         r.cmd = r.v0 + signed_span($urandom_range(0, 1) ? (1 << 16) : (40 << 16));
         r.dt  = ($urandom_range(0, 4) == 0) ? DT_W'($urandom()) :
                 DT_W'($urandom_range(300, 6554));
      end else if (k < 17) begin
         r.cmd = $urandom();
         r.v0  = $urandom();
         r.v1  = $urandom();
         r.dt  = DT_W'($urandom());
      end else begin
         r.cmd = corner_word();
         r.v0  = corner_word();
         r.v1  = corner_word();
         case ($urandom_range(0, 4))
            0: r.dt = '0;
            1: r.dt = '1;
            2: r.dt = 16'h0001;
            3: r.dt = 16'h8000;
            default: r.dt = DT_W'($urandom());
         endcase
      end
      return r;
   endfunction

   // a bound pair: usually straddling zero, sometimes inverted, equal or extreme
   function automatic void rand_limit_pair(int scale, output logic signed [VAL_W-1:0] lo,
                                           output logic signed [VAL_W-1:0] hi);
      case ($urandom_range(0, 9))
         0: begin
            lo = $urandom();
            hi = $urandom();
         end
         1: begin
            lo = $urandom_range(1, scale);
            hi = -int'($urandom_range(1, scale));
         end
         2: begin
            lo = VMIN;
            hi = VMAX;
         end
         3: begin
            lo = signed_span(scale);
            hi = lo;
         end
         default: begin
            lo = -int'($urandom_range(0, scale));
            hi = $urandom_range(0, scale);
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // start low with junk on the item ports, repeated n times
   task automatic drive_idle(int n);
      repeat (n) begin
         start              <= 1'b0;
         req_cmd_velocity   <= $urandom();
         req_prev_velocity  <= $urandom();
         req_prev2_velocity <= $urandom();
         req_time_step      <= DT_W'($urandom());
         @(posedge clock);
      end
   endtask

   // start stays high on return so back-to-back items need no extra edge
   task automatic send_item(req_type r);
      start              <= 1'b1;
      req_cmd_velocity   <= r.cmd;
      req_prev_velocity  <= r.v0;
      req_prev2_velocity <= r.v1;
      req_time_step      <= r.dt;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_command(r);
      items_sent++;
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // all seven registers, written only with the pipeline empty
   task automatic write_config(cfg_type c);
      logic [CSR_IDX_W-1:0] idx_list [7];
      logic [VAL_W-1:0]     val_list [7];
      logic [VAL_W-1:0]     mask_word;
      mask_word      = $urandom();
      mask_word[2:0] = c.enable_mask;
      idx_list = '{CSR_ENABLE_MASK, CSR_VEL_MIN, CSR_VEL_MAX, CSR_ACCEL_MIN,
                   CSR_ACCEL_MAX, CSR_JERK_MIN, CSR_JERK_MAX};
      val_list = '{mask_word, c.vel_min, c.vel_max, c.accel_min,
                   c.accel_max, c.jerk_min, c.jerk_max};
      for (int i = 0; i < 7; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= idx_list[i];
         csr_wdata    <= val_list[i];
         @(posedge clock);
         sb.write_reg(idx_list[i], val_list[i]);
      end
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      cfg_type c;
      bit      burst;
      int      g;
      sb = new();
      reset              = 1'b1;
      start              = 1'b0;
      req_cmd_velocity   = '0;
      req_prev_velocity  = '0;
      req_prev2_velocity = '0;
      req_time_step      = '0;
      csr_write_en       = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      drive_idle(2);

      // reset limits, all stages off: pass-through, zero command, field extremes
      send_item('{0, 5 << 16, 3 << 16, 16'h0CCD});
      send_item('{VMAX, VMIN, VMAX, 16'hFFFF});
      send_item('{VMIN, VMAX, VMIN, 16'h0000});
      send_item('{-1, 0, 0, 16'h0001});
      wait_drain();
      settings_used++;

      // every stage on with ordinary bounds
      c = '{enable_mask: M_VEL | M_ACCEL | M_JERK,
            vel_min: -(10 << 16), vel_max: 10 << 16,
            accel_min: -(5 << 16), accel_max: 5 << 16,
            jerk_min: -(100 << 16), jerk_max: 100 << 16};
      write_config(c);
      send_item('{20 << 16, 0, 0, 16'h0CCD});
      send_item('{-(20 << 16), 2 << 16, 1 << 16, 16'h0CCD});
      send_item('{3 << 16, 2 << 16, 1 << 16, 16'h0CCD});
      send_item('{VMAX, VMAX, VMIN, 16'h0000});
      send_item('{0, 9 << 16, 8 << 16, 16'h1000});
      wait_drain();

      // jerk only with extreme bounds: stage result saturation in both directions
      c = '{enable_mask: M_JERK, vel_min: VMAX, vel_max: VMIN,
            accel_min: VMAX, accel_max: VMIN, jerk_min: VMIN, jerk_max: VMAX};
      write_config(c);
      send_item('{VMIN, VMAX, VMIN, 16'h0000});
      send_item('{VMAX, VMIN, VMAX, 16'h0000});
      send_item('{VMAX, 0, 0, 16'hFFFF});
      send_item('{VMIN, 0, 0, 16'hFFFF});
      wait_drain();

      // acceleration and velocity with inverted bounds: the upper bound wins
      c = '{enable_mask: M_VEL | M_ACCEL, vel_min: 5 << 16, vel_max: -(5 << 16),
            accel_min: 1 << 16, accel_max: -(1 << 16), jerk_min: 0, jerk_max: 0};
      write_config(c);
      send_item('{2 << 16, 0, 0, 16'h8000});
      send_item('{-(3 << 16), 1 << 16, 0, 16'hFFFF});
      send_item('{0, 0, 0, 16'h0000});
      wait_drain();

      // velocity pinned at full scale: ratio saturates both ways
      c = '{enable_mask: M_VEL, vel_min: VMAX, vel_max: VMAX,
            accel_min: 0, accel_max: 0, jerk_min: 0, jerk_max: 0};
      write_config(c);
      send_item('{1, 0, 0, 16'h0000});
      send_item('{-1, 0, 0, 16'h0000});
      send_item('{VMIN, 0, 0, 16'hFFFF});
      send_item('{0, 0, 0, 16'h0000});
      wait_drain();

      // random part: one limit setting per phase, every enable combination twice
      for (int ph = 0; ph < PHASES; ph++) begin
         c.enable_mask = 3'(ph);
         rand_limit_pair(100 << 16, c.vel_min, c.vel_max);
         rand_limit_pair(50 << 16, c.accel_min, c.accel_max);
         rand_limit_pair(500 << 16, c.jerk_min, c.jerk_max);
         write_config(c);
         // some phases run flat out, the rest with short and occasional long gaps
         burst = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < PER_PHASE; k++) begin
            send_item(rand_command());
            if (k == PER_PHASE / 2 && (ph == 5 || $urandom_range(0, 3) == 0)) begin
               wait_drain();
            end else if (!burst) begin
               g = pick_gap();
               if (g > 0) drive_idle(g);
            end
         end
         wait_drain();
      end

      drive_idle(LATENCY + 5);
      $display("sent %0d items under %0d limit settings, all enable masks and bound shapes",
               items_sent, settings_used);
      $display("compared %0d results, %0d mismatches", sb.compared, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
